@@ hdl/rpnisc_pkg.sv @@
// rpnisc_pkg: token codes, status codes and stack cell commands
// shared by the stack cells, the multiply/divide unit and the top level
`default_nettype none
package rpnisc_pkg;

   localparam int VALUE_W = 64;

   // token codes
   localparam logic [3:0] OP_CLEAR = 4'd0;
   localparam logic [3:0] OP_PUSH  = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_DIV   = 4'd5;
   localparam logic [3:0] OP_DUP   = 4'd6;
   localparam logic [3:0] OP_NEG   = 4'd7;
   localparam logic [3:0] OP_DUPC  = 4'd8;
   localparam logic [3:0] OP_SWAP  = 4'd9;
   localparam logic [3:0] OP_ADDXY = 4'd10;
   localparam logic [3:0] OP_SUBXY = 4'd11;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DIV0  = 2'd3;

   // stack cell commands
   typedef logic [2:0] cell_cmd_type;
   localparam cell_cmd_type CELL_HOLD     = 3'd0;
   localparam cell_cmd_type CELL_FROM_UP1 = 3'd1;
   localparam cell_cmd_type CELL_FROM_UP2 = 3'd2;
   localparam cell_cmd_type CELL_FROM_DN1 = 3'd3;
   localparam cell_cmd_type CELL_LOAD     = 3'd4;

   // multiply/divide unit request
   typedef struct packed {
      logic                 start;
      logic                 is_div;
      logic [VALUE_W-1:0]   a;
      logic [VALUE_W-1:0]   b;
   } md_req_type;

endpackage
`default_nettype wire

@@ hdl/rpnisc_req_if.sv @@
// rpnisc_req_if: token channel, valid/ready with token payload
// depends on nothing
`default_nettype none
interface rpnisc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [63:0] operand_value;
   modport source (output valid, req_type, operand_value, input ready);
   modport sink   (input valid, req_type, operand_value, output ready);
endinterface
`default_nettype wire

@@ hdl/rpnisc_rsp_if.sv @@
// rpnisc_rsp_if: result channel, valid/ready with status, top value and depth payload
// depends on nothing
`default_nettype none
interface rpnisc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] top_value;
   logic [4:0]  stack_depth;
   modport source (output valid, status, top_value, stack_depth, input ready);
   modport sink   (input valid, status, top_value, stack_depth, output ready);
endinterface
`default_nettype wire

@@ hdl/rpnisc_cell.sv @@
// rpnisc_cell: one stack entry, loads from a neighbour or from the alu
// depends on rpnisc_pkg
`default_nettype none
module rpnisc_cell
   import rpnisc_pkg::*;
(
   input  wire logic               clock,
   input  wire cell_cmd_type       cmd,
   input  wire logic [VALUE_W-1:0] up1_value,
   input  wire logic [VALUE_W-1:0] up2_value,
   input  wire logic [VALUE_W-1:0] dn1_value,
   input  wire logic [VALUE_W-1:0] load_value,
   output logic      [VALUE_W-1:0] value
);
   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      unique case (cmd)
         CELL_FROM_UP1: value_in = up1_value;
         CELL_FROM_UP2: value_in = up2_value;
         CELL_FROM_DN1: value_in = dn1_value;
         CELL_LOAD:     value_in = load_value;
         default:       value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

@@ hdl/rpnisc_muldiv.sv @@
// rpnisc_muldiv: bit-serial 64-bit wrapping multiply and truncating divide
// depends on rpnisc_pkg
`default_nettype none
module rpnisc_muldiv
   import rpnisc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire md_req_type         req,
   output logic                    done,
   output logic      [VALUE_W-1:0] result
);
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [5:0]         count_ff, count_in;
   logic [VALUE_W:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0] dsr_ff, dsr_in;
   logic [VALUE_W:0]   shifted, diff;
   logic [VALUE_W-1:0] mag_a, mag_b;

   always_comb begin
      mag_a   = req.a[VALUE_W-1] ? (VALUE_W'(0) - req.a) : req.a;
      mag_b   = req.b[VALUE_W-1] ? (VALUE_W'(0) - req.b) : req.b;
      shifted = {rem_ff[VALUE_W-1:0], quo_ff[VALUE_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in = div_ff; neg_in = neg_ff; count_in = count_ff;
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         div_in   = req.is_div;
         count_in = '0;
         rem_in   = '0;
         if (req.is_div) begin
            neg_in = req.a[VALUE_W-1] ^ req.b[VALUE_W-1];
            quo_in = mag_a;
            dsr_in = mag_b;
         end else begin
            neg_in = 1'b0;
            quo_in = req.b;
            dsr_in = req.a;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!diff[VALUE_W]) begin
               rem_in = diff;
               quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
            end
         end else begin
            // shift-add: accumulate multiplicand for each set multiplier bit
            if (quo_ff[0]) rem_in = {1'b0, rem_ff[VALUE_W-1:0] + dsr_ff};
            quo_in = {1'b0, quo_ff[VALUE_W-1:1]};
            dsr_in = {dsr_ff[VALUE_W-2:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in; neg_ff <= neg_in; count_ff <= count_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (VALUE_W'(0) - quo_ff) : quo_ff)
                          : rem_ff[VALUE_W-1:0];
endmodule
`default_nettype wire

@@ hdl/rpn_integer_stack_calculator.sv @@
// rpn_integer_stack_calculator: top level, token decode, cell row and result register
// depends on rpnisc_pkg, rpnisc_req_if, rpnisc_rsp_if, rpnisc_cell, rpnisc_muldiv
//
// Postfix calculator on a stack of 64-bit two's complement values held in a row
// of cells, top of stack in cell 0. Each token shifts, loads or holds every cell.
// For most tokens the cells are written on acceptance and the result register
// loads from them after that; the next token is taken once it has loaded.
// Multiply and divide go through a bit-serial unit at one operand bit a cycle,
// then write the cells and load the result register. A new token is accepted
// while the previous result waits on rsp. After an empty-stack, full-stack or
// divide-by-zero error every token is ignored until clear, but each still
// returns a result with the held status.
`default_nettype none
module rpn_integer_stack_calculator
   import rpnisc_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)(
   input  wire logic  clock,
   input  wire logic  reset,
   rpnisc_req_if.sink   req_channel,
   rpnisc_rsp_if.source rsp_channel
);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W:0] DEPTH_C = (SP_W+1)'(STACK_DEPTH);

   // controller states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_BUSY   = 2'd1;
   localparam logic [1:0] S_REPORT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [1:0]         err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [VALUE_W-1:0] rsp_top_ff;
   logic [4:0]         rsp_depth_ff;

   logic [VALUE_W-1:0] cell_q [STACK_DEPTH];
   cell_cmd_type       cmd0, cmd1, cmd_rest;
   logic [VALUE_W-1:0] load0, load1;
   md_req_type         md_req;
   logic               md_done;
   logic [VALUE_W-1:0] md_result;
   logic               accept, slot_free;
   logic [SP_W:0]      sp_x;
   logic [VALUE_W-1:0] c0, c1, c2;

   assign accept    = req_channel.valid && req_channel.ready;
   assign slot_free = !rsp_valid_ff || rsp_channel.ready;
   assign sp_x      = {1'b0, sp_ff};
   assign c0 = cell_q[0];
   assign c1 = cell_q[1];
   assign c2 = cell_q[2];

   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      err_in   = err_ff;
      cmd0 = CELL_HOLD; cmd1 = CELL_HOLD; cmd_rest = CELL_HOLD;
      load0 = c0; load1 = c1;
      md_req.start  = 1'b0;
      md_req.is_div = (req_channel.req_type == OP_DIV);
      md_req.a      = c1;
      md_req.b      = c0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            state_in = S_REPORT;
            if (req_channel.req_type == OP_CLEAR) begin
               sp_in  = '0;
               err_in = ST_OK;
            end else if (err_ff == ST_OK) begin
               unique case (req_channel.req_type)
                  OP_PUSH: begin
                     if (sp_x + 1 > DEPTH_C) err_in = ST_FULL;
                     else begin
                        cmd0 = CELL_LOAD; load0 = req_channel.operand_value;
                        cmd1 = CELL_FROM_UP1; cmd_rest = CELL_FROM_UP1;
                        sp_in = sp_ff + 1'b1;
                     end
                  end
                  OP_ADD, OP_SUB: begin
                     if (sp_x < 2) err_in = ST_EMPTY;
                     else begin
                        cmd0  = CELL_LOAD;
                        load0 = (req_channel.req_type == OP_ADD) ? c1 + c0 : c1 - c0;
                        cmd1 = CELL_FROM_DN1; cmd_rest = CELL_FROM_DN1;
                        sp_in = sp_ff - 1'b1;
                     end
                  end
                  OP_MUL, OP_DIV: begin
                     if (sp_x < 2) err_in = ST_EMPTY;
                     else if (req_channel.req_type == OP_DIV && c0 == '0)
                        err_in = ST_DIV0;
                     else begin
                        md_req.start = 1'b1;
                        state_in     = S_BUSY;
                     end
                  end
                  OP_DUP: begin
                     if (sp_x < 1) err_in = ST_EMPTY;
                     else if (sp_x + 1 > DEPTH_C) err_in = ST_FULL;
                     else begin
                        cmd1 = CELL_FROM_UP1; cmd_rest = CELL_FROM_UP1;
                        sp_in = sp_ff + 1'b1;
                     end
                  end
                  OP_NEG: begin
                     if (sp_x < 1) err_in = ST_EMPTY;
                     else begin
                        cmd0 = CELL_LOAD; load0 = VALUE_W'(0) - c0;
                     end
                  end
                  OP_DUPC: begin
                     if (sp_x < 2) err_in = ST_EMPTY;
                     else if (sp_x + 2 > DEPTH_C) err_in = ST_FULL;
                     else begin
                        cmd_rest = CELL_FROM_UP2;
                        sp_in = sp_ff + 2'd2;
                     end
                  end
                  OP_SWAP: begin
                     if (sp_x < 2) err_in = ST_EMPTY;
                     else begin
                        cmd0 = CELL_LOAD; load0 = c1;
                        cmd1 = CELL_LOAD; load1 = c0;
                     end
                  end
                  OP_ADDXY, OP_SUBXY: begin
                     if (sp_x < 3) err_in = ST_EMPTY;
                     else begin
                        cmd0 = CELL_LOAD; cmd1 = CELL_LOAD; cmd_rest = CELL_FROM_DN1;
                        if (req_channel.req_type == OP_ADDXY) begin
                           load0 = c1 + c0; load1 = c2 + c0;
                        end else begin
                           load0 = c1 - c0; load1 = c2 - c0;
                        end
                        sp_in = sp_ff - 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BUSY: if (md_done) begin
            // binary result replaces the top pair
            cmd0 = CELL_LOAD; load0 = md_result;
            cmd1 = CELL_FROM_DN1; cmd_rest = CELL_FROM_DN1;
            sp_in    = sp_ff - 1'b1;
            state_in = S_REPORT;
         end
         S_REPORT: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // row of cells, neighbours beyond the ends read as zero
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      rpnisc_cell u_cell (
         .clock      (clock),
         .cmd        ((i == 0) ? cmd0 : ((i == 1) ? cmd1 : cmd_rest)),
         .up1_value  ((i >= 1) ? cell_q[(i >= 1) ? i - 1 : 0] : '0),
         .up2_value  ((i >= 2) ? cell_q[(i >= 2) ? i - 2 : 0] : '0),
         .dn1_value  ((i < STACK_DEPTH - 1) ? cell_q[(i < STACK_DEPTH - 1) ? i + 1 : i] : '0),
         .load_value ((i == 0) ? load0 : ((i == 1) ? load1 : '0)),
         .value      (cell_q[i])
      );
   end

   rpnisc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .req    (md_req),
      .done   (md_done),
      .result (md_result)
   );

   // result register loads from the settled stack state
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      if (state_ff == S_REPORT && slot_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_REPORT && slot_free) begin
         rsp_status_ff <= err_ff;
         rsp_top_ff    <= (sp_ff != '0) ? c0 : '0;
         rsp_depth_ff  <= 5'(sp_ff);
      end
   end

   assign req_channel.ready       = (state_ff == S_IDLE);
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.status      = rsp_status_ff;
   assign rsp_channel.top_value   = rsp_top_ff;
   assign rsp_channel.stack_depth = rsp_depth_ff;

   // stack pointer never exceeds the row length
   assert property (@(posedge clock) disable iff (reset) sp_x <= DEPTH_C)
      else $error("stack pointer beyond depth");
   // an accepted token always leaves idle
   assert property (@(posedge clock) disable iff (reset) accept |=> state_ff != S_IDLE)
      else $error("token accepted without leaving idle");
   // the unit only reports back while the controller waits for it
   assert property (@(posedge clock) disable iff (reset) md_done |-> state_ff == S_BUSY)
      else $error("unit result outside busy state");
   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_channel.ready |=> rsp_valid_ff && $stable(rsp_top_ff))
      else $error("pending result lost");
endmodule
`default_nettype wire

@@ test/tb_rpnisc_scoreboard.sv @@
// tb_rpnisc_scoreboard: stack calculator predictor and queue of expected results
// depends on rpnisc_pkg
`timescale 1ns / 1ps
import rpnisc_pkg::*;

typedef struct packed {
   logic [1:0]  status;
   logic [63:0] top_value;
   logic [4:0]  stack_depth;
} calc_result_type;

class calc_scoreboard;
   localparam int DEPTH = 16;
   logic [63:0]     stack_mem [DEPTH];
   int unsigned     sp;
   logic [1:0]      err;
   calc_result_type pending_results[$];
   int              mismatches;

   function void clear_state();
      sp = 0;
      err = ST_OK;
      pending_results.delete();
      mismatches = 0;
   endfunction

   // returns 1 when the operand count and the room allow the token
   function bit room_ok(int unsigned need, int unsigned grow);
      if (sp < need) begin
         err = ST_EMPTY;
         return 0;
      end
      if (sp + grow > DEPTH) begin
         err = ST_FULL;
         return 0;
      end
      return 1;
   endfunction

   function logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function void note_token(logic [3:0] op, logic [63:0] v);
      logic [63:0] a, b, c;
      calc_result_type r;
      int unsigned n;
      n = sp;
      if (op == OP_CLEAR) begin
         sp = 0;
         err = ST_OK;
      end else if (err == ST_OK) begin
         case (op)
            OP_PUSH: if (room_ok(0, 1)) begin
               stack_mem[n] = v;
               sp = n + 1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (room_ok(2, 0)) begin
               a = stack_mem[n-2];
               b = stack_mem[n-1];
               if (op == OP_DIV && b == 0) err = ST_DIV0;
               else begin
                  case (op)
                     OP_ADD: a = a + b;
                     OP_SUB: a = a - b;
                     OP_MUL: a = a * b;
                     default: a = quotient(a, b);
                  endcase
                  stack_mem[n-2] = a;
                  sp = n - 1;
               end
            end
            OP_DUP: if (room_ok(1, 1)) begin
               stack_mem[n] = stack_mem[n-1];
               sp = n + 1;
            end
            OP_NEG: if (room_ok(1, 0)) stack_mem[n-1] = -stack_mem[n-1];
            OP_DUPC: if (room_ok(2, 2)) begin
               stack_mem[n] = stack_mem[n-2];
               stack_mem[n+1] = stack_mem[n-1];
               sp = n + 2;
            end
            OP_SWAP: if (room_ok(2, 0)) begin
               a = stack_mem[n-2];
               stack_mem[n-2] = stack_mem[n-1];
               stack_mem[n-1] = a;
            end
            OP_ADDXY, OP_SUBXY: if (room_ok(3, 0)) begin
               a = stack_mem[n-3];
               b = stack_mem[n-2];
               c = stack_mem[n-1];
               stack_mem[n-3] = (op == OP_ADDXY) ? a + c : a - c;
               stack_mem[n-2] = (op == OP_ADDXY) ? b + c : b - c;
               sp = n - 1;
            end
            default: ;
         endcase
      end
      r.status = err;
      r.top_value = (sp > 0) ? stack_mem[sp-1] : 64'd0;
      r.stack_depth = sp[4:0];
      pending_results = {pending_results, r};
   endfunction

   function void check_result(calc_result_type got);
      calc_result_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result st=%0d top=%h depth=%0d",
                     got.status, got.top_value, got.stack_depth);
         return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected st=%0d top=%h depth=%0d, got st=%0d top=%h depth=%0d",
                     want.status, want.top_value, want.stack_depth,
                     got.status, got.top_value, got.stack_depth);
      end
   endfunction
endclass

@@ test/tb_rpn_integer_stack_calculator.sv @@
// tb_rpn_integer_stack_calculator: directed and random token programs against the
// scoreboard predictor; depends on rpnisc_pkg, both channel interfaces and the scoreboard
`timescale 1ns / 1ps
import rpnisc_pkg::*;

module tb_rpn_integer_stack_calculator;
   logic clock;
   logic reset;
   rpnisc_req_if req_channel();
   rpnisc_rsp_if rsp_channel();

   rpn_integer_stack_calculator #(.STACK_DEPTH(16)) uut (
      .clock(clock), .reset(reset),
      .req_channel(req_channel.sink), .rsp_channel(rsp_channel.source)
   );

   calc_scoreboard board;
   int send_idle_pct;  // chance in a hundred that the sender idles instead of sending
   int recv_stall_pct; // chance in a hundred that the receiver holds ready low
   int tokens_sent;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // accepted transactions on both channels, sampled at the edge
   always @(posedge clock) begin
      if (!reset && req_channel.valid && req_channel.ready)
         board.note_token(req_channel.req_type, req_channel.operand_value);
      if (!reset && rsp_channel.valid && rsp_channel.ready)
         board.check_result({rsp_channel.status, rsp_channel.top_value,
                             rsp_channel.stack_depth});
   end

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp_channel.ready <= 1'b0;
      else rsp_channel.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // one token transaction, with an optional idle gap in front
   task automatic send_token(logic [3:0] op, logic [63:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_channel.valid <= 1'b0;
         @(posedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.req_type <= op;
      req_channel.operand_value <= v;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
      tokens_sent++;
   endtask

   function automatic logic [63:0] rand_value();
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return 64'h8000_0000_0000_0000;
         2: return 64'h7fff_ffff_ffff_ffff;
         3: return {64{1'b1}};
         4: return 64'd0;
         default: return 64'($signed($urandom_range(20)) - 10);
      endcase
   endfunction

   // weighted towards tokens that do work on a live stack
   function automatic logic [3:0] rand_op();
      int k;
      k = $urandom_range(99);
      if (k < 2) return OP_CLEAR;
      if (k < 35) return OP_PUSH;
      if (k < 38) return 4'($urandom_range(15, 12)); // unknown codes
      return 4'($urandom_range(OP_SUBXY, OP_ADD));
   endfunction

   // one well-formed program: clear, some pushes, then random tokens
   task automatic random_program(int len);
      send_token(OP_CLEAR, rand_value());
      repeat ($urandom_range(4, 1)) send_token(OP_PUSH, rand_value());
      repeat (len) send_token(rand_op(), rand_value());
   endtask

   task automatic directed_part();
      send_token(OP_ADD, 64'd5);                  // empty stack error
      send_token(OP_PUSH, 64'd1);                 // ignored while sticky
      send_token(OP_CLEAR, 64'd0);
      send_token(OP_PUSH, 64'h8000_0000_0000_0000);
      send_token(OP_PUSH, {64{1'b1}});
      send_token(OP_DIV, 64'd0);                  // most negative over minus one
      send_token(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
      send_token(OP_DUP, 64'd0);
      send_token(OP_ADD, 64'd0);                  // wraps
      send_token(OP_DUP, 64'd0);
      send_token(OP_MUL, 64'd0);
      send_token(OP_NEG, 64'd0);
      send_token(OP_PUSH, 64'd7);
      send_token(OP_DUPC, 64'd0);
      send_token(OP_SWAP, 64'd0);
      send_token(OP_SUB, 64'd0);
      send_token(OP_ADDXY, 64'd0);
      send_token(OP_PUSH, 64'd3);
      send_token(OP_SUBXY, 64'd0);
      send_token(4'd15, 64'd0);                   // unknown code
      send_token(OP_PUSH, 64'd0);
      send_token(OP_DIV, 64'd0);                  // divide by zero
      send_token(OP_CLEAR, 64'd0);
      repeat (17) send_token(OP_PUSH, 64'd9);     // overflow on the last
   endtask

   initial begin
      board = new();
      board.clear_state();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tokens_sent = 0;
      reset = 1'b1;
      req_channel.valid = 1'b0;
      req_channel.req_type = OP_CLEAR;
      req_channel.operand_value = 64'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      // idling phases: none, sender, receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 10 : 0;
         recv_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 10 : 0;
         while (tokens_sent < 25 + 390 * (ph + 1))
            random_program($urandom_range(30, 4));
      end
      req_channel.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("tb_rpn_integer_stack_calculator passed");
      else
         $display("tb_rpn_integer_stack_calculator failed");
      $finish;
   end

   // run limit, well above the slowest correct run
   initial begin
      #100_000_000;
      $display("tb_rpn_integer_stack_calculator failed");
      $finish;
   end
endmodule
